FILE: hdl/tpr_pkg.sv
// Shared types, type codes and value helpers for the typed property record parser.
// Used by tpr_parser, tpr_out_stage and typed_property_record_parser.
package tpr_pkg;

  localparam logic [7:0] TY_S = 8'h53;
  localparam logic [7:0] TY_R = 8'h52;
  localparam logic [7:0] TY_Y = 8'h59;
  localparam logic [7:0] TY_C = 8'h43;
  localparam logic [7:0] TY_B = 8'h42;
  localparam logic [7:0] TY_I = 8'h49;
  localparam logic [7:0] TY_F = 8'h46;
  localparam logic [7:0] TY_D = 8'h44;
  localparam logic [7:0] TY_L = 8'h4C;
  localparam logic [7:0] TY_LOWER_A = 8'h61;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [2:0] KIND_SCALAR     = 3'd0;
  localparam logic [2:0] KIND_ELEMENT    = 3'd1;
  localparam logic [2:0] KIND_RAW        = 3'd2;
  localparam logic [2:0] KIND_COMPRESSED = 3'd3;
  localparam logic [2:0] KIND_EMPTY      = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN    = 3'd5;

  typedef struct packed {
    logic [7:0]         record_type;
    logic [2:0]         result_kind;
    logic signed [63:0] element_value;
    logic [31:0]        element_number;
    logic               last_of_record;
  } result_t;

  function automatic logic [3:0] scalar_size(input logic [7:0] t);
    logic [3:0] s;
    case (t)
      TY_Y:       s = 4'd2;
      TY_C, TY_B: s = 4'd1;
      TY_I, TY_F: s = 4'd4;
      TY_D, TY_L: s = 4'd8;
      default:    s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] finish_value(input logic [7:0] t, input logic [63:0] v);
    logic [63:0] r;
    case (t)
      TY_Y:       r = {{48{v[15]}}, v[15:0]};
      TY_C, TY_B: r = {63'd0, |v[7:0]};
      TY_I:       r = {{32{v[31]}}, v[31:0]};
      TY_F:       r = {32'd0, v[31:0]};
      default:    r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/tpr_parser.sv
// Record phase machine: consumes one byte per transfer and forms at most one result.
// Depends on tpr_pkg for type codes, result kinds and value helpers.
module tpr_parser import tpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  output logic       push_o,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN, PH_RAW, PH_SCALAR, PH_ACOUNT, PH_AENC, PH_ACLEN, PH_APAY
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] asm_q, asm_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] count_q, count_d;
  logic        comp_q, comp_d;
  logic [31:0] elem_q, elem_d;

  logic [63:0] asm_take;
  logic [7:0]  elem_type;
  logic [3:0]  pos_next;
  logic        rem_last;

  assign asm_take  = asm_q | ({56'd0, data_byte_i} << {pos_q, 3'b000});
  assign elem_type = type_q - CASE_GAP;
  assign pos_next  = {1'b0, pos_q} + 4'd1;
  assign rem_last  = rem_q <= 32'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    asm_d    = asm_q;
    type_d   = type_q;
    rem_d    = rem_q;
    count_d  = count_q;
    comp_d   = comp_q;
    elem_d   = elem_q;
    push_o   = 1'b0;
    result_o = '{record_type: type_q, result_kind: KIND_SCALAR, element_value: 64'sd0,
                 element_number: 32'd0, last_of_record: 1'b0};
    case (phase_q)
      PH_TYPE: begin
        type_d = data_byte_i;
        asm_d  = 64'd0;
        pos_d  = 3'd0;
        elem_d = 32'd0;
        comp_d = 1'b0;
        rem_d  = 32'd0;
        if (data_byte_i inside {TY_S, TY_R}) begin
          phase_d = PH_LEN;
        end else if (scalar_size(data_byte_i) != 4'd0) begin
          phase_d = PH_SCALAR;
        end else if (data_byte_i >= TY_LOWER_A &&
                     scalar_size(data_byte_i - CASE_GAP) != 4'd0) begin
          phase_d = PH_ACOUNT;
        end else begin
          push_o = 1'b1;
          result_o.record_type    = data_byte_i;
          result_o.result_kind    = KIND_UNKNOWN;
          result_o.last_of_record = 1'b1;
        end
      end
      PH_LEN: begin
        if (pos_q == 3'd3) begin
          rem_d = asm_take[31:0];
          asm_d = 64'd0;
          pos_d = 3'd0;
          if (asm_take[31:0] == 32'd0) begin
            push_o = 1'b1;
            result_o.result_kind    = KIND_EMPTY;
            result_o.last_of_record = 1'b1;
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_RAW;
          end
        end else begin
          asm_d = asm_take;
          pos_d = pos_q + 3'd1;
        end
      end
      PH_RAW: begin
        push_o = 1'b1;
        result_o.result_kind    = KIND_RAW;
        result_o.element_value  = {56'd0, data_byte_i};
        result_o.element_number = elem_q;
        result_o.last_of_record = rem_last;
        elem_d = elem_q + 32'd1;
        rem_d  = rem_q - 32'd1;
        if (rem_q == 32'd1) phase_d = PH_TYPE;
      end
      PH_SCALAR: begin
        if (pos_next >= scalar_size(type_q)) begin
          push_o = 1'b1;
          result_o.result_kind    = KIND_SCALAR;
          result_o.element_value  = finish_value(type_q, asm_take);
          result_o.last_of_record = 1'b1;
          asm_d   = 64'd0;
          pos_d   = 3'd0;
          phase_d = PH_TYPE;
        end else begin
          asm_d = asm_take;
          pos_d = pos_q + 3'd1;
        end
      end
      PH_ACOUNT, PH_AENC, PH_ACLEN: begin
        if (pos_q != 3'd3) begin
          asm_d = asm_take;
          pos_d = pos_q + 3'd1;
        end else begin
          asm_d = 64'd0;
          pos_d = 3'd0;
          if (phase_q == PH_ACOUNT) begin
            count_d = asm_take[31:0];
            phase_d = PH_AENC;
          end else if (phase_q == PH_AENC) begin
            comp_d  = asm_take[31:0] != 32'd0;
            phase_d = PH_ACLEN;
          end else begin
            rem_d = comp_q ? asm_take[31:0] : count_q;
            if (rem_d == 32'd0) begin
              push_o = 1'b1;
              result_o.result_kind    = KIND_EMPTY;
              result_o.last_of_record = 1'b1;
              phase_d = PH_TYPE;
            end else begin
              phase_d = PH_APAY;
            end
          end
        end
      end
      PH_APAY: begin
        if (comp_q) begin
          push_o = 1'b1;
          result_o.result_kind    = KIND_COMPRESSED;
          result_o.element_value  = {56'd0, data_byte_i};
          result_o.element_number = elem_q;
          result_o.last_of_record = rem_last;
          elem_d = elem_q + 32'd1;
          rem_d  = rem_q - 32'd1;
          if (rem_q == 32'd1) phase_d = PH_TYPE;
        end else if (pos_next >= scalar_size(elem_type)) begin
          push_o = 1'b1;
          result_o.result_kind    = KIND_ELEMENT;
          result_o.element_value  = finish_value(elem_type, asm_take);
          result_o.element_number = elem_q;
          result_o.last_of_record = rem_last;
          elem_d = elem_q + 32'd1;
          rem_d  = rem_q - 32'd1;
          asm_d  = 64'd0;
          pos_d  = 3'd0;
          if (rem_q == 32'd1) phase_d = PH_TYPE;
        end else begin
          asm_d = asm_take;
          pos_d = pos_q + 3'd1;
        end
      end
      default: phase_d = PH_TYPE;
    endcase
    if (!take_i) push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      pos_q   <= 3'd0;
      asm_q   <= 64'd0;
      type_q  <= 8'd0;
      rem_q   <= 32'd0;
      count_q <= 32'd0;
      comp_q  <= 1'b0;
      elem_q  <= 32'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      asm_q   <= asm_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
      count_q <= count_d;
      comp_q  <= comp_d;
      elem_q  <= elem_d;
    end
  end

endmodule

FILE: hdl/tpr_out_stage.sv
// Result register with a one-entry skid buffer between the parser and the output channel.
// Depends on tpr_pkg for the result record type.
module tpr_out_stage import tpr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t result_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign pop      = out_valid_q && !stall_i;
  assign full_o   = skid_valid_q;
  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : result_i;
    end else if (push_i) begin
      skid_q <= result_i;
    end
  end

endmodule

FILE: hdl/typed_property_record_parser.sv
// Top level of the typed property record parser.
// Depends on tpr_pkg, tpr_parser and tpr_out_stage.
//
// The input channel carries one byte of a binary property stream per transfer
// (in_valid_i, in_stall_o, data_byte_i). The output channel carries one parsed
// result per transfer (out_valid_o, out_stall_i and the five result fields).
// Header, length and partial value bytes produce no result, except that an unknown
// type byte or the last byte of a zero length yields one; every other byte yields one.
// A byte is parsed in the cycle it is transferred and its result is registered,
// or held in the skid buffer on a stall. The block accepts one byte every cycle
// while the receiver keeps up, a rate set by the phase machine's per-byte update.
// When the receiver stalls, the output register holds its result unchanged and
// a one-entry skid buffer takes the next result; once that buffer is occupied,
// in_stall_o is raised until the output transfer drains it.
// Reset clears the phase machine to wait for a type byte and empties both the
// output register and the skid buffer.
module typed_property_record_parser import tpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         record_type_o,
  output logic [2:0]         result_kind_o,
  output logic signed [63:0] element_value_o,
  output logic [31:0]        element_number_o,
  output logic               last_of_record_o
);

  logic    take;
  logic    push;
  logic    full;
  result_t parsed;
  result_t shown;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  tpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .result_o    (parsed)
  );

  tpr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (parsed),
    .full_o   (full),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (shown)
  );

  assign record_type_o    = shown.record_type;
  assign result_kind_o    = shown.result_kind;
  assign element_value_o  = shown.element_value;
  assign element_number_o = shown.element_number;
  assign last_of_record_o = shown.last_of_record;

endmodule
